// File: rtl/fal_pkg.sv
// ----------------------------------------------------------------------------
// fal_pkg
// Shared widths and codes of the free-list entry allocator.
// ----------------------------------------------------------------------------
package fal_pkg;

  // Field widths of the item ports
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int STS_W      = 3;
  localparam int CFG_W      = 11;
  localparam int IN_DATA_W  = 16;                    // entry_index padded to bytes
  localparam int OUT_DATA_W = IDX_W + 2 * CNT_W;     // 32 bits, already whole bytes

  localparam logic [CFG_W-1:0] INIT_ENTRIES_RST = 11'd32;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_NEXT = 2'd0,
    KIND_AT   = 2'd1,
    KIND_FREE = 2'd2
  } fal_kind_t;

  // Result status codes
  typedef enum logic [STS_W-1:0] {
    STS_DONE    = 3'd0,
    STS_TAKEN   = 3'd1,
    STS_NO_ROOM = 3'd2,
    STS_CORRUPT = 3'd3,
    STS_BAD_REQ = 3'd4
  } fal_status_t;

endpackage

// File: rtl/free_list_entry_allocator.sv
// ----------------------------------------------------------------------------
// free_list_entry_allocator
// Free-list allocator over a table of fixed-size entries, kept in two
// single-port-style synchronous memories (link word and taken flag).
// ----------------------------------------------------------------------------
// Items go one at a time. Allocate next passes ST_POP_RD, ST_POP_WR and
// ST_FINISH; with the free list empty the table first grows, chaining
// GROW_STEP new entries in ST_GROW and hooking them on in ST_GFIX. Allocate
// at grows the table the same way up to the index if needed, reads the entry
// (ST_AT_RD, ST_AT_CHK) and finishes if it is taken or sits at the list
// head; otherwise it walks for the predecessor (the walk reads one link word
// per cycle through the link memory's single read port), then ST_UNLINK
// unlinks the entry. Free pushes the entry at the front from ST_FR_CHK, or
// appends it at the tail and ends it in ST_FR_END. Requests refused at accept
// (no room to grow, unknown kind, free beyond the table) go straight to
// ST_FINISH; a free of an entry that is not taken is refused in ST_FR_CHK.
// Growth initializes new entries one memory word per cycle. Reset and every
// write of the initial-entries register rebuild the table over the initial
// entries (at most MAX_ENTRIES), with no item accepted. A finished result
// sits in an output register, and the next item is accepted while it waits.
// ----------------------------------------------------------------------------
module free_list_entry_allocator
  import fal_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int GROW_STEP   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write: initial entries
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data,
  // Request items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] entry_index, [15:10] zero
  input  logic [KIND_W-1:0]     in_tuser,   // [1:0] kind
  // Result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [9:0] granted_index,
                                            // [20:10] allocated_count,
                                            // [31:21] entries_in_use
  output logic [STS_W-1:0]      out_tuser   // [2:0] status
);

  // Index / link width: one bit above the address so the all-ones end
  // marker never collides with a real entry.
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int LW = AW + 1;
  localparam int CW = (LW > CNT_W) ? LW : CNT_W;
  localparam int GW = CW + 1;          // compare width, room for size + step

  localparam logic [LW-1:0] LINK_END = '1;

  typedef enum logic [13:0] {
    ST_BUILD  = 14'b00000000000001,
    ST_IDLE   = 14'b00000000000010,
    ST_GROW   = 14'b00000000000100,
    ST_GFIX   = 14'b00000000001000,
    ST_POP_RD = 14'b00000000010000,
    ST_POP_WR = 14'b00000000100000,
    ST_AT_RD  = 14'b00000001000000,
    ST_AT_CHK = 14'b00000010000000,
    ST_WALK   = 14'b00000100000000,
    ST_UNLINK = 14'b00001000000000,
    ST_FR_RD  = 14'b00010000000000,
    ST_FR_CHK = 14'b00100000000000,
    ST_FR_END = 14'b01000000000000,
    ST_FINISH = 14'b10000000000000
  } fal_state_t;

  // Control state
  fal_state_t state_r, state_nxt;
  logic [CFG_W-1:0] init_r, init_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] tail_r, tail_nxt;
  logic [LW-1:0] goal_r, goal_nxt;
  logic [LW-1:0] count_r, count_nxt;
  logic [LW-1:0] size_r, size_nxt;
  logic [LW-1:0] ptr_r, ptr_nxt;
  logic out_valid_r, out_valid_nxt;

  // Payload
  fal_kind_t kind_r, kind_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [LW-1:0] last_r, last_nxt;
  logic [LW-1:0] gnew_r, gnew_nxt;
  logic [LW-1:0] prev_r, prev_nxt;
  logic [LW-1:0] steps_r, steps_nxt;
  logic [LW-1:0] vlink_r, vlink_nxt;
  fal_status_t res_sts_r, res_sts_nxt;
  logic [IDX_W-1:0] res_gnt_r, res_gnt_nxt;
  logic [STS_W-1:0] out_sts_r, out_sts_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Memories: link words and taken flags
  logic [LW-1:0] link_mem [MAX_ENTRIES];
  logic          taken_mem [MAX_ENTRIES];
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] rd_link_r;
  logic          rd_tkn_r;
  logic          we_link;
  logic [AW-1:0] wa_link;
  logic [LW-1:0] wd_link;
  logic          we_tkn;
  logic [AW-1:0] wa_tkn;
  logic          wd_tkn;

  // Derived values
  logic [LW-1:0]    n_build;     // clamped initial entries
  logic [IDX_W-1:0] in_idx;
  logic             in_beyond;   // requested index lies past the table
  logic [LW-1:0]    v;           // latched index, valid once inside the table
  logic [LW-1:0]    step_cnt;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sts_r;

  assign in_idx    = in_tdata[IDX_W-1:0];
  assign in_beyond = GW'(in_idx) >= GW'(size_r);
  assign v         = LW'(idx_r);
  assign step_cnt  = LW'(steps_r + 1'b1);

  always_comb begin
    if (init_r == '0) begin
      n_build = LW'(1);
    end else if (GW'(init_r) > GW'(MAX_ENTRIES)) begin
      n_build = LW'(MAX_ENTRIES);
    end else begin
      n_build = LW'(init_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    goal_nxt      = goal_r;
    count_nxt     = count_r;
    size_nxt      = size_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    gnew_nxt      = gnew_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    vlink_nxt     = vlink_r;
    res_sts_nxt   = res_sts_r;
    res_gnt_nxt   = res_gnt_r;
    out_sts_nxt   = out_sts_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    we_link       = 1'b0;
    wa_link       = '0;
    wd_link       = '0;
    we_tkn        = 1'b0;
    wa_tkn        = '0;
    wd_tkn        = 1'b0;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_BUILD: begin
        // Rebuild: all free, chained in index order
        head_nxt  = '0;
        tail_nxt  = LW'(n_build - 1'b1);
        goal_nxt  = LINK_END;
        count_nxt = '0;
        size_nxt  = n_build;
        we_link   = 1'b1;
        wa_link   = ptr_r[AW-1:0];
        wd_link   = (LW'(ptr_r + 1'b1) < n_build) ? LW'(ptr_r + 1'b1) : LINK_END;
        we_tkn    = 1'b1;
        wa_tkn    = ptr_r[AW-1:0];
        wd_tkn    = 1'b0;
        if (ptr_r == LW'(n_build - 1'b1)) begin
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = LW'(ptr_r + 1'b1);
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt    = fal_kind_t'(in_tuser);
          idx_nxt     = in_idx;
          res_gnt_nxt = '0;
          unique case (in_tuser)
            KIND_NEXT: begin
              if (head_r != LINK_END) begin
                state_nxt = ST_POP_RD;
              end else if (GW'(size_r) + GW'(GROW_STEP) > GW'(MAX_ENTRIES)) begin
                res_sts_nxt = STS_NO_ROOM;
                state_nxt   = ST_FINISH;
              end else begin
                ptr_nxt   = size_r;
                last_nxt  = LW'(GW'(size_r) + GW'(GROW_STEP) - 1'b1);
                gnew_nxt  = LINK_END;
                state_nxt = ST_GROW;
              end
            end
            KIND_AT: begin
              if (!in_beyond) begin
                state_nxt = ST_AT_RD;
              end else if (GW'(in_idx) >= GW'(MAX_ENTRIES)) begin
                res_sts_nxt = STS_NO_ROOM;
                state_nxt   = ST_FINISH;
              end else begin
                // Grow up to and including the requested index
                ptr_nxt   = size_r;
                last_nxt  = LW'(in_idx);
                gnew_nxt  = size_r;
                state_nxt = ST_GROW;
              end
            end
            KIND_FREE: begin
              if (in_beyond) begin
                res_sts_nxt = STS_BAD_REQ;
                state_nxt   = ST_FINISH;
              end else begin
                state_nxt = ST_FR_RD;
              end
            end
            default: begin
              res_sts_nxt = STS_BAD_REQ;
              state_nxt   = ST_FINISH;
            end
          endcase
        end
      end

      ST_GROW: begin
        // Chain the new entries one word per cycle
        we_link = 1'b1;
        wa_link = ptr_r[AW-1:0];
        wd_link = (ptr_r == last_r) ? LINK_END : LW'(ptr_r + 1'b1);
        we_tkn  = 1'b1;
        wa_tkn  = ptr_r[AW-1:0];
        wd_tkn  = 1'b0;
        if (ptr_r == last_r) begin
          state_nxt = ST_GFIX;
        end else begin
          ptr_nxt = LW'(ptr_r + 1'b1);
        end
      end

      ST_GFIX: begin
        // Hook the new run behind the old tail, or make it the list
        if (head_r != LINK_END) begin
          if (tail_r < size_r) begin
            we_link = 1'b1;
            wa_link = tail_r[AW-1:0];
            wd_link = size_r;
          end
        end else begin
          head_nxt = size_r;
        end
        tail_nxt  = last_r;
        goal_nxt  = gnew_r;
        size_nxt  = LW'(last_r + 1'b1);
        state_nxt = (kind_r == KIND_NEXT) ? ST_POP_RD : ST_AT_RD;
      end

      ST_POP_RD: begin
        if (head_r >= size_r) begin
          res_sts_nxt = STS_CORRUPT;
          state_nxt   = ST_FINISH;
        end else begin
          rd_en       = 1'b1;
          rd_addr     = head_r[AW-1:0];
          prev_nxt    = head_r;
          res_gnt_nxt = IDX_W'(head_r);
          state_nxt   = ST_POP_WR;
        end
      end

      ST_POP_WR: begin
        head_nxt = rd_link_r;
        if (rd_link_r == LINK_END) begin
          tail_nxt = LINK_END;
        end
        we_tkn      = 1'b1;
        wa_tkn      = prev_r[AW-1:0];
        wd_tkn      = 1'b1;
        count_nxt   = LW'(count_r + 1'b1);
        res_sts_nxt = STS_DONE;
        state_nxt   = ST_FINISH;
      end

      ST_AT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = v[AW-1:0];
        state_nxt = ST_AT_CHK;
      end

      ST_AT_CHK: begin
        vlink_nxt = rd_link_r;
        if (rd_tkn_r) begin
          res_sts_nxt = STS_TAKEN;
          res_gnt_nxt = idx_r;
          state_nxt   = ST_FINISH;
        end else if (head_r == v) begin
          head_nxt = rd_link_r;
          if (rd_link_r == LINK_END) begin
            tail_nxt = LINK_END;
          end
          we_tkn      = 1'b1;
          wa_tkn      = v[AW-1:0];
          wd_tkn      = 1'b1;
          count_nxt   = LW'(count_r + 1'b1);
          res_sts_nxt = STS_DONE;
          res_gnt_nxt = idx_r;
          state_nxt   = ST_FINISH;
        end else if (head_r >= size_r) begin
          res_sts_nxt = STS_CORRUPT;
          state_nxt   = ST_FINISH;
        end else begin
          // Start the walk for the predecessor
          rd_en     = 1'b1;
          rd_addr   = head_r[AW-1:0];
          prev_nxt  = head_r;
          steps_nxt = '0;
          state_nxt = ST_WALK;
        end
      end

      ST_WALK: begin
        if (rd_link_r == v) begin
          state_nxt = ST_UNLINK;
        end else begin
          steps_nxt = step_cnt;
          if (step_cnt > size_r || rd_link_r >= size_r) begin
            res_sts_nxt = STS_CORRUPT;
            state_nxt   = ST_FINISH;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = rd_link_r[AW-1:0];
            prev_nxt = rd_link_r;
          end
        end
      end

      ST_UNLINK: begin
        we_link = 1'b1;
        wa_link = prev_r[AW-1:0];
        wd_link = vlink_r;
        we_tkn  = 1'b1;
        wa_tkn  = v[AW-1:0];
        wd_tkn  = 1'b1;
        if (tail_r == v) begin
          tail_nxt = prev_r;
        end
        count_nxt   = LW'(count_r + 1'b1);
        res_sts_nxt = STS_DONE;
        res_gnt_nxt = idx_r;
        state_nxt   = ST_FINISH;
      end

      ST_FR_RD: begin
        rd_en     = 1'b1;
        rd_addr   = v[AW-1:0];
        state_nxt = ST_FR_CHK;
      end

      ST_FR_CHK: begin
        if (!rd_tkn_r) begin
          res_sts_nxt = STS_BAD_REQ;
          state_nxt   = ST_FINISH;
        end else begin
          we_tkn = 1'b1;
          wa_tkn = v[AW-1:0];
          wd_tkn = 1'b0;
          if (count_r != '0) begin
            count_nxt = LW'(count_r - 1'b1);
          end
          if (v < goal_r) begin
            // Push at the front
            we_link  = 1'b1;
            wa_link  = v[AW-1:0];
            wd_link  = head_r;
            head_nxt = v;
            if (tail_r == LINK_END) begin
              tail_nxt = v;
            end
            res_sts_nxt = STS_DONE;
            res_gnt_nxt = idx_r;
            state_nxt   = ST_FINISH;
          end else begin
            // Append at the tail; terminate the entry next cycle
            if (tail_r != LINK_END && tail_r < size_r) begin
              we_link = 1'b1;
              wa_link = tail_r[AW-1:0];
              wd_link = v;
            end else begin
              head_nxt = v;
            end
            state_nxt = ST_FR_END;
          end
        end
      end

      ST_FR_END: begin
        we_link     = 1'b1;
        wa_link     = v[AW-1:0];
        wd_link     = LINK_END;
        tail_nxt    = v;
        res_sts_nxt = STS_DONE;
        res_gnt_nxt = idx_r;
        state_nxt   = ST_FINISH;
      end

      ST_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sts_nxt   = res_sts_r;
          out_data_nxt  = {CNT_W'(size_r), CNT_W'(count_r), res_gnt_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_BUILD;
        ptr_nxt   = '0;
      end
    endcase

    // A register write restarts the rebuild pass
    if (cfg_valid) begin
      init_nxt  = cfg_data;
      ptr_nxt   = '0;
      state_nxt = ST_BUILD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BUILD;
      init_r      <= INIT_ENTRIES_RST;
      head_r      <= '0;
      tail_r      <= '0;
      goal_r      <= LINK_END;
      count_r     <= '0;
      size_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      goal_r      <= goal_nxt;
      count_r     <= count_nxt;
      size_r      <= size_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    idx_r      <= idx_nxt;
    last_r     <= last_nxt;
    gnew_r     <= gnew_nxt;
    prev_r     <= prev_nxt;
    steps_r    <= steps_nxt;
    vlink_r    <= vlink_nxt;
    res_sts_r  <= res_sts_nxt;
    res_gnt_r  <= res_gnt_nxt;
    out_sts_r  <= out_sts_nxt;
    out_data_r <= out_data_nxt;
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_link_r <= link_mem[rd_addr];
      rd_tkn_r  <= taken_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we_link) begin
      link_mem[wa_link] <= wd_link;
    end
  end

  always_ff @(posedge clk) begin
    if (we_tkn) begin
      taken_mem[wa_tkn] <= wd_tkn;
    end
  end

`ifndef SYNTHESIS
  // Allocated entries always lie inside the table
  a_count_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= size_r)
    else $error("allocated count exceeds table size");

  // Outside a rebuild the table only grows
  a_size_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_BUILD |=> size_r >= $past(size_r))
    else $error("table size shrank outside rebuild");

  // A finished item reaches the output register as soon as it is free
  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH && (!out_valid_r || out_tready) |=> out_tvalid)
    else $error("finished item not presented");

  // A granted entry lies inside the reported table
  a_grant_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STS_DONE |->
      CNT_W'(out_tdata[IDX_W-1:0]) < out_tdata[OUT_DATA_W-1 -: CNT_W])
    else $error("granted entry outside the table");
`endif

endmodule

// File: verif/free_list_entry_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// free_list_entry_allocator_tb
// Drives allocate-next, allocate-at, free and unknown requests through the
// allocator across several table sizes. A shadow copy of the free list
// predicts every result, and each result item is matched field by field.
// ----------------------------------------------------------------------------

// Shadow of the allocator: its own free list, taken flags and counters,
// plus the queue of results still owed by the block.
class free_list_shadow #(int unsigned TBL_MAX = 1024, int unsigned GROW_BY = 16);

  localparam int unsigned LINK_END  = 32'hFFFF;
  localparam int unsigned GOAL_NONE = 32'hFFFF;

  typedef struct {
    fal_pkg::fal_status_t           status;
    logic [fal_pkg::IDX_W-1:0]      granted;
    logic [fal_pkg::CNT_W-1:0]      alloc_cnt;
    logic [fal_pkg::CNT_W-1:0]      tbl_size;
  } grant_t;

  int unsigned link_of[TBL_MAX];
  bit          taken[TBL_MAX];
  int unsigned head, tail, goal, alloc_cnt, tbl_size;
  grant_t      expected_grants[$];
  int          mismatch_cnt;

  function new();
    mismatch_cnt = 0;
    reload(fal_pkg::INIT_ENTRIES_RST);
  endfunction

  // Rebuild the table: every entry free, chained in index order.
  function void reload(logic [fal_pkg::CFG_W-1:0] value);
    int unsigned n;
    n = 32'(value);
    if (n == 0) n = 1;
    if (n > TBL_MAX) n = TBL_MAX;
    for (int unsigned i = 0; i < TBL_MAX; i++) begin
      link_of[i] = (i + 1 < n) ? i + 1 : LINK_END;
      taken[i]   = 1'b0;
    end
    head      = 0;
    tail      = n - 1;
    goal      = GOAL_NONE;
    alloc_cnt = 0;
    tbl_size  = n;
  endfunction

  // Append add fresh entries behind the old tail; refuse past capacity.
  function bit extend(int unsigned add, int unsigned new_goal);
    int unsigned old, last;
    old = tbl_size;
    if (old > TBL_MAX || add > TBL_MAX - old) return 1'b0;
    last = old + add - 1;
    for (int unsigned i = old; i <= last; i++) begin
      link_of[i] = (i < last) ? i + 1 : LINK_END;
      taken[i]   = 1'b0;
    end
    if (head != LINK_END) begin
      if (tail < old) link_of[tail] = old;
    end else begin
      head = old;
    end
    tail     = last;
    goal     = new_goal;
    tbl_size = old + add;
    return 1'b1;
  endfunction

  function fal_pkg::fal_status_t claim_next(output int unsigned granted);
    int unsigned e;
    granted = 0;
    if (head == LINK_END && !extend(GROW_BY, GOAL_NONE)) return fal_pkg::STS_NO_ROOM;
    e = head;
    if (e >= tbl_size) return fal_pkg::STS_CORRUPT;
    head     = link_of[e];
    taken[e] = 1'b1;
    if (head == LINK_END) tail = LINK_END;
    alloc_cnt++;
    granted = e;
    return fal_pkg::STS_DONE;
  endfunction

  function fal_pkg::fal_status_t claim_at(int unsigned v, output int unsigned granted);
    int unsigned prev, nxt, steps;
    granted = 0;
    if (v >= tbl_size && !extend(v - tbl_size + 1, tbl_size)) return fal_pkg::STS_NO_ROOM;
    if (taken[v]) begin
      granted = v;
      return fal_pkg::STS_TAKEN;
    end
    if (head == v) begin
      head = link_of[v];
    end else begin
      // walk to the predecessor of v; bail out on a broken chain
      prev  = head;
      steps = 0;
      forever begin
        if (prev == LINK_END || prev >= tbl_size) return fal_pkg::STS_CORRUPT;
        nxt = link_of[prev];
        if (nxt == v) break;
        prev = nxt;
        steps++;
        if (steps > tbl_size) return fal_pkg::STS_CORRUPT;
      end
      link_of[prev] = link_of[v];
      if (tail == v) tail = prev;
    end
    if (head == LINK_END) tail = LINK_END;
    taken[v] = 1'b1;
    alloc_cnt++;
    granted = v;
    return fal_pkg::STS_DONE;
  endfunction

  function fal_pkg::fal_status_t release_at(int unsigned v, output int unsigned granted);
    granted = 0;
    if (v >= tbl_size || !taken[v]) return fal_pkg::STS_BAD_REQ;
    if (v < goal) begin
      link_of[v] = head;
      head       = v;
      if (tail == LINK_END) tail = v;
    end else begin
      if (tail != LINK_END && tail < tbl_size) link_of[tail] = v;
      else head = v;
      tail       = v;
      link_of[v] = LINK_END;
    end
    taken[v] = 1'b0;
    if (alloc_cnt > 0) alloc_cnt--;
    granted = v;
    return fal_pkg::STS_DONE;
  endfunction

  // Note an accepted request and queue the result it must produce.
  function void take_request(logic [fal_pkg::KIND_W-1:0] kind,
                             logic [fal_pkg::IDX_W-1:0] idx);
    grant_t      g;
    int unsigned granted;
    granted = 0;
    case (kind)
      fal_pkg::KIND_NEXT: g.status = claim_next(granted);
      fal_pkg::KIND_AT:   g.status = claim_at(32'(idx), granted);
      fal_pkg::KIND_FREE: g.status = release_at(32'(idx), granted);
      default:            g.status = fal_pkg::STS_BAD_REQ;
    endcase
    g.granted   = granted[fal_pkg::IDX_W-1:0];
    g.alloc_cnt = alloc_cnt[fal_pkg::CNT_W-1:0];
    g.tbl_size  = tbl_size[fal_pkg::CNT_W-1:0];
    expected_grants.push_back(g);
  endfunction

  // Match one result item against the oldest outstanding prediction.
  function void match_result(logic [fal_pkg::STS_W-1:0] status,
                             logic [fal_pkg::IDX_W-1:0] granted,
                             logic [fal_pkg::CNT_W-1:0] cnt,
                             logic [fal_pkg::CNT_W-1:0] size);
    grant_t g;
    if (expected_grants.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("unexpected result: status %0d index %0d count %0d size %0d",
                 status, granted, cnt, size);
      return;
    end
    g = expected_grants.pop_front();
    if (status !== g.status || granted !== g.granted ||
        cnt !== g.alloc_cnt || size !== g.tbl_size) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch: exp status %0d index %0d count %0d size %0d, got %0d %0d %0d %0d",
                 g.status, g.granted, g.alloc_cnt, g.tbl_size, status, granted, cnt, size);
    end
  endfunction

endclass

module free_list_entry_allocator_tb;
  import fal_pkg::*;

  localparam int unsigned TBL_MAX      = 1024;
  localparam int unsigned GROW_BY      = 16;
  localparam int          HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int          DRAIN_CYCLES = 200;    // quiet time after the last result
  localparam longint      TIMEOUT_NS   = 64'd50_000_000;

  // The package names only the three legal kinds; the fourth must be rejected.
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

  // Idling modes: none, sender gaps, receiver stalls, both
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_SENDER = 1;
  localparam int IDLE_SINK   = 2;
  localparam int IDLE_BOTH   = 3;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [9:0] entry_index, [15:10] zero
  logic [KIND_W-1:0]     in_tuser   = '0;   // [1:0] kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [9:0] granted_index,
                                            // [20:10] allocated_count,
                                            // [31:21] entries_in_use
  logic [STS_W-1:0]      out_tuser;         // [2:0] status

  int          src_idle_pct   = 0;          // read only by the request driver
  int          sink_stall_pct = 0;          // read by the result sink at the edge
  int unsigned hold_seq       = 0;          // bump to request one long hold-off

  free_list_shadow #(TBL_MAX, GROW_BY) shadow;

  free_list_entry_allocator #(
    .MAX_ENTRIES (TBL_MAX),
    .GROW_STEP   (GROW_BY)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  // Monitor: sample every handshake at the edge. Results are matched before
  // the new request is predicted; a result can never belong to a request
  // accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        shadow.match_result(out_tuser, out_tdata[IDX_W-1:0],
                            out_tdata[IDX_W+CNT_W-1:IDX_W],
                            out_tdata[IDX_W+2*CNT_W-1:IDX_W+CNT_W]);
      if (cfg_valid && cfg_ready)
        shadow.reload(cfg_data);
      if (in_tvalid && in_tready)
        shadow.take_request(in_tuser, in_tdata[IDX_W-1:0]);
    end
  end

  // Result sink: random stalls, and a long hold-off whenever hold_seq moves.
  // During the hold-off the sender keeps offering items, so the output
  // register fills and the block has to push back on its input.
  initial begin : result_sink
    int          hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      IDLE_SENDER: begin
        src_idle_pct   = 47;
        sink_stall_pct <= 0;
      end
      IDLE_SINK: begin
        src_idle_pct   = 0;
        sink_stall_pct <= 47;
      end
      IDLE_BOTH: begin
        src_idle_pct   = 14;
        sink_stall_pct <= 14;
      end
      default: begin
        src_idle_pct   = 0;
        sink_stall_pct <= 0;
      end
    endcase
  endtask

  // Offer one request item and hold it until the block takes it. Valid stays
  // high straight into the next item unless a gap is rolled.
  task automatic issue_request(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_DATA_W-IDX_W){1'b0}}, idx};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (shadow.expected_grants.size() != 0);
  endtask

  // Rewrite the table size; only ever called with the block idle.
  task automatic write_initial_entries(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random mix of requests. Allocate-at indexes stay below span so the walks
  // stay short in small tables; frees mostly target an entry that is taken.
  task automatic run_mix(input int n_items, input int unsigned span,
                         input int pct_next, input int pct_at, input int pct_free);
    int          roll;
    int unsigned pick, start, probe;
    for (int k = 0; k < n_items; k++) begin
      if (k % 50 == 0) set_idling((k / 50) % 4);
      roll = $urandom_range(0, 99);
      if (roll < pct_next) begin
        issue_request(KIND_NEXT, IDX_W'($urandom_range(0, TBL_MAX - 1)));
      end else if (roll < pct_next + pct_at) begin
        issue_request(KIND_AT, IDX_W'($urandom_range(0, span - 1)));
      end else if (roll < pct_next + pct_at + pct_free) begin
        pick = $urandom_range(0, span - 1);
        if ($urandom_range(0, 99) < 80 && shadow.alloc_cnt > 0) begin
          start = $urandom_range(0, shadow.tbl_size - 1);
          for (int unsigned s = 0; s < shadow.tbl_size; s++) begin
            probe = (start + s) % shadow.tbl_size;
            if (shadow.taken[probe]) begin
              pick = probe;
              break;
            end
          end
        end
        issue_request(KIND_FREE, IDX_W'(pick));
      end else begin
        issue_request(KIND_UNKNOWN, IDX_W'($urandom_range(0, TBL_MAX - 1)));
      end
    end
  endtask

  initial begin : stimulus
    shadow = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset table of 32 entries.
    set_idling(IDLE_NONE);
    issue_request(KIND_NEXT, 10'd0);        // pop the head
    issue_request(KIND_NEXT, 10'h3FF);      // index is ignored for next
    issue_request(KIND_AT,   10'd5);        // unlink by walking
    issue_request(KIND_AT,   10'd5);        // already taken
    issue_request(KIND_AT,   10'd2);        // target sits at the head
    issue_request(KIND_AT,   10'd31);       // target is the tail
    issue_request(KIND_FREE, 10'd5);        // no goal: push at the front
    issue_request(KIND_FREE, 10'd5);        // not taken: rejected
    issue_request(KIND_FREE, 10'd40);       // beyond the table: rejected
    issue_request(KIND_UNKNOWN, 10'h2AA);   // unknown kind: rejected
    issue_request(KIND_AT,   10'h155);      // grow the table up to the index
    issue_request(KIND_AT,   10'h2AA);      // grow again, goal moves up
    issue_request(KIND_AT,   10'h3FF);      // grow to full capacity
    issue_request(KIND_FREE, 10'h3FF);      // above the goal: append at tail
    issue_request(KIND_FREE, 10'h155);      // below the goal: push at front
    issue_request(KIND_AT,   10'd0);        // taken
    issue_request(KIND_FREE, 10'd0);
    issue_request(KIND_AT,   10'd0);        // freed entry is now the head
    issue_request(KIND_NEXT, 10'h155);
    issue_request(KIND_FREE, 10'd31);
    issue_request(KIND_AT,   10'h3FF);      // walk to the far tail entry

    // Zero acts as a single entry: the table grows from one.
    write_initial_entries(11'd0);
    run_mix(150, 24, 35, 30, 30);

    // Mid-size table, with one long receiver hold-off at the start.
    write_initial_entries(11'd100);
    hold_seq <= hold_seq + 1;
    run_mix(200, 128, 30, 35, 30);

    write_initial_entries(11'd1);
    run_mix(120, 40, 35, 30, 30);

    // Above capacity acts as full capacity. Drain the free list with mostly
    // allocate-next until growth is refused.
    write_initial_entries(11'd2047);
    run_mix(1200, TBL_MAX, 94, 2, 3);

    // Full table freshly chained: long walks, a few items only.
    write_initial_entries(11'd1024);
    hold_seq <= hold_seq + 1;
    run_mix(60, TBL_MAX, 25, 45, 25);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatch_cnt == 0 && shadow.expected_grants.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
rtl/fal_pkg.sv
rtl/free_list_entry_allocator.sv
verif/free_list_entry_allocator_tb.sv
